// ===== rtl/lsed_pkg.sv =====
// ----------------------------------------------------------------------------
// lsed_pkg
// Shared types and character codes for the literal string escape decoder.
// ----------------------------------------------------------------------------
package lsed_pkg;

    localparam int BYTE_W = 8;
    localparam int CHAR_W = 9;
    localparam int CNT_W  = 2;

    localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'd92;
    localparam logic [BYTE_W-1:0] CH_N         = 8'd110;
    localparam logic [BYTE_W-1:0] CH_R         = 8'd114;
    localparam logic [BYTE_W-1:0] CH_T         = 8'd116;
    localparam logic [BYTE_W-1:0] CH_ZERO      = 8'd48;
    localparam logic [BYTE_W-1:0] CH_SEVEN     = 8'd55;

    localparam logic [CHAR_W-1:0] CODE_LF  = 9'd10;
    localparam logic [CHAR_W-1:0] CODE_CR  = 9'd13;
    localparam logic [CHAR_W-1:0] CODE_TAB = 9'd9;

    localparam logic [CNT_W-1:0] OCTAL_MAX_DIGITS = 2'd3;

    typedef enum logic [1:0] {
        MODE_PLAIN  = 2'd0,
        MODE_ESCAPE = 2'd1,
        MODE_OCTAL  = 2'd2
    } mode_t;

    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] code;
        logic              fin;
    } result_t;

endpackage

// ===== rtl/literal_string_escape_decoder.sv =====
// ----------------------------------------------------------------------------
// literal_string_escape_decoder
// Decodes backslash escapes of a string body, one byte per beat.
// ----------------------------------------------------------------------------
// Path: an accepted byte waits in the input register, then its result is
// registered in the output register behind m_. Throughput: one byte per cycle
// while m_ready allows; a byte that ends an octal run and gives two results
// holds the input register until its second result leaves pend_reg.
// Reset: synchronous aresetn clears all beats in flight and the escape state.
// ----------------------------------------------------------------------------
module literal_string_escape_decoder (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [lsed_pkg::BYTE_W-1:0]   s_byte_in,
    input  logic                          s_end_of_string,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [lsed_pkg::CHAR_W-1:0]   m_char_out,
    output logic                          m_final_char
);
    import lsed_pkg::*;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_eos_reg;

    mode_t             mode_reg, mode_next;
    logic [CHAR_W-1:0] val_reg, val_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    result_t           out_reg, pend_reg;
    result_t           r0, r1;

    logic              proc;
    logic              is_oct;
    logic [2:0]        digit;
    logic [CHAR_W-1:0] byte_code;
    logic [CHAR_W-1:0] oct_acc;
    logic [CNT_W-1:0]  cnt_inc;

    assign proc    = in_valid_reg && !pend_reg.valid && (!out_reg.valid || m_ready);
    assign s_ready = !in_valid_reg || proc;

    assign is_oct    = (in_byte_reg >= CH_ZERO) && (in_byte_reg <= CH_SEVEN);
    assign digit     = in_byte_reg[2:0];
    assign byte_code = {1'b0, in_byte_reg};
    assign oct_acc   = {val_reg[CHAR_W-4:0], digit};
    assign cnt_inc   = cnt_reg + 2'd1;

    always_comb begin
        mode_next = mode_reg;
        val_next  = val_reg;
        cnt_next  = cnt_reg;
        r0        = '0;
        r1        = '0;
        unique case (mode_reg)
            MODE_ESCAPE: begin
                mode_next = MODE_PLAIN;
                if (in_byte_reg == CH_N) begin
                    r0 = '{valid: 1'b1, code: CODE_LF, fin: in_eos_reg};
                end else if (in_byte_reg == CH_R) begin
                    r0 = '{valid: 1'b1, code: CODE_CR, fin: in_eos_reg};
                end else if (in_byte_reg == CH_T) begin
                    r0 = '{valid: 1'b1, code: CODE_TAB, fin: in_eos_reg};
                end else if (is_oct) begin
                    val_next = {6'd0, digit};
                    cnt_next = 2'd1;
                    if (in_eos_reg) begin
                        r0 = '{valid: 1'b1, code: {6'd0, digit}, fin: 1'b1};
                    end else begin
                        mode_next = MODE_OCTAL;
                    end
                end else begin
                    r0 = '{valid: 1'b1, code: byte_code, fin: in_eos_reg};
                end
            end
            MODE_OCTAL: begin
                if (is_oct) begin
                    val_next = oct_acc;
                    cnt_next = cnt_inc;
                    if (cnt_inc == OCTAL_MAX_DIGITS || in_eos_reg) begin
                        r0        = '{valid: 1'b1, code: oct_acc, fin: in_eos_reg};
                        mode_next = MODE_PLAIN;
                        val_next  = '0;
                        cnt_next  = '0;
                    end
                end else begin
                    r0        = '{valid: 1'b1, code: val_reg, fin: 1'b0};
                    mode_next = MODE_PLAIN;
                    val_next  = '0;
                    cnt_next  = '0;
                    if (in_byte_reg == CH_BACKSLASH && !in_eos_reg) begin
                        mode_next = MODE_ESCAPE;
                    end else begin
                        r1 = '{valid: 1'b1, code: byte_code, fin: in_eos_reg};
                    end
                end
            end
            default: begin
                mode_next = MODE_PLAIN;
                if (in_byte_reg == CH_BACKSLASH && !in_eos_reg) begin
                    mode_next = MODE_ESCAPE;
                end else begin
                    r0 = '{valid: 1'b1, code: byte_code, fin: in_eos_reg};
                end
            end
        endcase
        if (in_eos_reg) begin
            mode_next = MODE_PLAIN;
            val_next  = '0;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            mode_reg       <= MODE_PLAIN;
            val_reg        <= '0;
            cnt_reg        <= '0;
            out_reg.valid  <= 1'b0;
            pend_reg.valid <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (proc) begin
                mode_reg <= mode_next;
                val_reg  <= val_next;
                cnt_reg  <= cnt_next;
                out_reg  <= r0;
                pend_reg <= r1;
            end else if (out_reg.valid && m_ready) begin
                out_reg        <= pend_reg;
                pend_reg.valid <= 1'b0;
            end
        end
        if (s_valid && s_ready) begin
            in_byte_reg <= s_byte_in;
            in_eos_reg  <= s_end_of_string;
        end
    end

    assign m_valid      = out_reg.valid;
    assign m_char_out   = out_reg.code;
    assign m_final_char = out_reg.fin;

    a_pend_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg.valid |-> out_reg.valid)
        else $error("pending result without a result ahead of it");

    a_clear_on_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && in_eos_reg) |=> (mode_reg == MODE_PLAIN && cnt_reg == '0 && val_reg == '0))
        else $error("escape state not cleared after final byte");

    a_octal_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_OCTAL) |-> (cnt_reg == 2'd1 || cnt_reg == 2'd2))
        else $error("octal run with bad digit count");

    a_idle_octal: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg != MODE_OCTAL) |-> (cnt_reg == '0 && val_reg == '0))
        else $error("octal accumulator not clear outside a run");

    a_pend_after_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg.valid && m_ready) |=> (out_reg.valid && !pend_reg.valid))
        else $error("pending result not moved forward");

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the literal string escape decoder. A short table of
// directed bytes covers the byte extremes, every escape kind, octal runs of
// one and three digits and many ways a run or a string can end. Random strings
// follow, mostly well formed with random content, plus raw noise bytes.
// Expected characters come from typed rows or a cycle-free decoder model kept
// in step with every accepted byte. The sender runs in bursts and the receiver
// stalls on its own pattern, including one long hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import lsed_pkg::*;

    localparam int N_ITEMS    = 2000;
    localparam int IDLE_LIMIT = 3000;
    localparam int LONG_HOLD  = 300;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              fin;
    } char_t;

    typedef struct packed {
        logic [BYTE_W-1:0] b;
        logic              eos;
    } in_beat_t;

    // one directed row; typed rows carry their expected characters
    typedef struct packed {
        logic [BYTE_W-1:0] b;
        logic              eos;
        logic              typed;
        logic [1:0]        n;
        logic [CHAR_W-1:0] c0;
        logic              f0;
        logic [CHAR_W-1:0] c1;
        logic              f1;
    } row_t;

    localparam row_t DIRECTED [26] = '{
        '{8'h41,        1'b0, 1'b1, 2'd1, 9'd65,    1'b0, 9'd0,   1'b0},
        '{8'h00,        1'b0, 1'b1, 2'd1, 9'd0,     1'b0, 9'd0,   1'b0},
        '{8'hFF,        1'b0, 1'b1, 2'd1, 9'd255,   1'b0, 9'd0,   1'b0},
        '{CH_BACKSLASH, 1'b0, 1'b1, 2'd0, 9'd0,     1'b0, 9'd0,   1'b0},
        '{CH_N,         1'b0, 1'b1, 2'd1, CODE_LF,  1'b0, 9'd0,   1'b0},
        '{CH_BACKSLASH, 1'b0, 1'b1, 2'd0, 9'd0,     1'b0, 9'd0,   1'b0},
        '{CH_T,         1'b0, 1'b1, 2'd1, CODE_TAB, 1'b0, 9'd0,   1'b0},
        '{CH_BACKSLASH, 1'b0, 1'b1, 2'd0, 9'd0,     1'b0, 9'd0,   1'b0},
        '{8'h29,        1'b0, 1'b1, 2'd1, 9'd41,    1'b0, 9'd0,   1'b0},
        '{CH_BACKSLASH, 1'b0, 1'b1, 2'd0, 9'd0,     1'b0, 9'd0,   1'b0},
        '{CH_SEVEN,     1'b0, 1'b1, 2'd0, 9'd0,     1'b0, 9'd0,   1'b0},
        '{CH_SEVEN,     1'b0, 1'b1, 2'd0, 9'd0,     1'b0, 9'd0,   1'b0},
        '{CH_SEVEN,     1'b0, 1'b1, 2'd1, 9'd511,   1'b0, 9'd0,   1'b0},
        '{CH_SEVEN,     1'b0, 1'b1, 2'd1, 9'd55,    1'b0, 9'd0,   1'b0},
        '{CH_BACKSLASH, 1'b0, 1'b0, 2'd0, 9'd0,     1'b0, 9'd0,   1'b0},
        '{8'h32,        1'b0, 1'b0, 2'd0, 9'd0,     1'b0, 9'd0,   1'b0},
        '{CH_BACKSLASH, 1'b0, 1'b0, 2'd0, 9'd0,     1'b0, 9'd0,   1'b0},
        '{CH_R,         1'b0, 1'b0, 2'd0, 9'd0,     1'b0, 9'd0,   1'b0},
        '{CH_BACKSLASH, 1'b0, 1'b0, 2'd0, 9'd0,     1'b0, 9'd0,   1'b0},
        '{8'h35,        1'b0, 1'b0, 2'd0, 9'd0,     1'b0, 9'd0,   1'b0},
        '{8'h78,        1'b1, 1'b1, 2'd2, 9'd5,     1'b0, 9'd120, 1'b1},
        '{CH_BACKSLASH, 1'b0, 1'b1, 2'd0, 9'd0,     1'b0, 9'd0,   1'b0},
        '{8'h0A,        1'b0, 1'b1, 2'd1, 9'd10,    1'b0, 9'd0,   1'b0},
        '{CH_BACKSLASH, 1'b0, 1'b1, 2'd0, 9'd0,     1'b0, 9'd0,   1'b0},
        '{8'h33,        1'b1, 1'b1, 2'd1, 9'd3,     1'b1, 9'd0,   1'b0},
        '{CH_BACKSLASH, 1'b1, 1'b1, 2'd1, 9'd92,    1'b1, 9'd0,   1'b0}
    };

    logic              aclk            = 1'b0;
    logic              aresetn         = 1'b0;
    logic              s_valid         = 1'b0;
    logic              s_ready;
    logic [BYTE_W-1:0] s_byte_in       = '0;
    logic              s_end_of_string = 1'b0;
    logic              m_valid;
    logic              m_ready         = 1'b0;
    logic [CHAR_W-1:0] m_char_out;
    logic              m_final_char;

    // decoder model state
    mode_t             dec_mode;
    logic [CHAR_W-1:0] oct_val;
    logic [CNT_W-1:0]  oct_cnt;

    char_t step_chars [$];
    char_t due_chars  [$];

    int n_sent      = 0;
    int n_strings   = 0;
    int n_checked   = 0;
    int n_errors    = 0;
    int burst_left  = 0;
    int idle_cycles = 0;
    int hold_left   = 0;
    int stretch     = 0;
    int rx_style    = 0;
    bit held        = 1'b0;

    literal_string_escape_decoder dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_byte_in       (s_byte_in),
        .s_end_of_string (s_end_of_string),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_char_out      (m_char_out),
        .m_final_char    (m_final_char)
    );

    always #10 aclk = ~aclk;

    function automatic bit is_octal_digit(logic [BYTE_W-1:0] b);
        return b >= CH_ZERO && b <= CH_SEVEN;
    endfunction

    function automatic void clear_octal();
        dec_mode = MODE_PLAIN;
        oct_val  = '0;
        oct_cnt  = '0;
    endfunction

    function automatic void take_plain(logic [BYTE_W-1:0] b, logic e);
        if (b == CH_BACKSLASH && !e) begin
            dec_mode = MODE_ESCAPE;
        end else begin
            step_chars.push_back('{code: {1'b0, b}, fin: e});
        end
    endfunction

    // decodes one byte into step_chars and advances the model state
    function automatic void decode_byte(logic [BYTE_W-1:0] b, logic e);
        logic [BYTE_W-1:0] digit;
        digit = b - CH_ZERO;
        step_chars.delete();
        case (dec_mode)
            MODE_ESCAPE: begin
                dec_mode = MODE_PLAIN;
                if (b == CH_N) begin
                    step_chars.push_back('{code: CODE_LF, fin: e});
                end else if (b == CH_R) begin
                    step_chars.push_back('{code: CODE_CR, fin: e});
                end else if (b == CH_T) begin
                    step_chars.push_back('{code: CODE_TAB, fin: e});
                end else if (is_octal_digit(b)) begin
                    oct_val = {6'd0, digit[2:0]};
                    oct_cnt = 2'd1;
                    if (e) begin
                        step_chars.push_back('{code: oct_val, fin: 1'b1});
                    end else begin
                        dec_mode = MODE_OCTAL;
                    end
                end else begin
                    step_chars.push_back('{code: {1'b0, b}, fin: e});
                end
            end
            MODE_OCTAL: begin
                if (is_octal_digit(b)) begin
                    oct_val = {oct_val[5:0], digit[2:0]};
                    oct_cnt = oct_cnt + 2'd1;
                    if (oct_cnt == OCTAL_MAX_DIGITS || e) begin
                        step_chars.push_back('{code: oct_val, fin: e});
                        clear_octal();
                    end
                end else begin
                    step_chars.push_back('{code: oct_val, fin: 1'b0});
                    clear_octal();
                    take_plain(b, e);
                end
            end
            default: begin
                dec_mode = MODE_PLAIN;
                take_plain(b, e);
            end
        endcase
        if (e) begin
            clear_octal();
        end
    endfunction

    task automatic send_item(input logic [BYTE_W-1:0] b, input logic e, input bit use_model);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid         <= 1'b1;
        s_byte_in       <= b;
        s_end_of_string <= e;
        do @(posedge aclk); while (!s_ready);
        n_sent++;
        if (e) begin
            n_strings++;
        end
        decode_byte(b, e);
        if (use_model) begin
            foreach (step_chars[i]) due_chars.push_back(step_chars[i]);
        end
    endtask

    // one random string: mostly escapes and plain bytes, sometimes raw noise
    task automatic build_string(ref in_beat_t beats [$]);
        int tokens;
        int digits;
        logic [BYTE_W-1:0] esc;
        beats.delete();
        if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 12)) begin
                beats.push_back('{b: 8'($urandom_range(0, 255)),
                                  eos: ($urandom_range(0, 7) == 0)});
            end
            return;
        end
        tokens = $urandom_range(1, 10);
        repeat (tokens) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: beats.push_back('{b: 8'($urandom_range(0, 255)), eos: 1'b0});
                4: begin
                    case ($urandom_range(0, 2))
                        0: esc = CH_N;
                        1: esc = CH_R;
                        default: esc = CH_T;
                    endcase
                    beats.push_back('{b: CH_BACKSLASH, eos: 1'b0});
                    beats.push_back('{b: esc, eos: 1'b0});
                end
                5: begin
                    case ($urandom_range(0, 2))
                        0: esc = 8'h28;
                        1: esc = 8'h29;
                        default: esc = CH_BACKSLASH;
                    endcase
                    beats.push_back('{b: CH_BACKSLASH, eos: 1'b0});
                    beats.push_back('{b: esc, eos: 1'b0});
                end
                6, 7: begin
                    digits = $urandom_range(1, 3);
                    beats.push_back('{b: CH_BACKSLASH, eos: 1'b0});
                    repeat (digits) begin
                        beats.push_back('{b: 8'(CH_ZERO + $urandom_range(0, 7)), eos: 1'b0});
                    end
                end
                8: begin
                    beats.push_back('{b: CH_BACKSLASH, eos: 1'b0});
                    beats.push_back('{b: 8'($urandom_range(0, 255)), eos: 1'b0});
                end
                default: begin
                    beats.push_back('{b: CH_BACKSLASH, eos: 1'b0});
                    beats.push_back('{b: 8'h0A, eos: 1'b0});
                end
            endcase
        end
        if ($urandom_range(0, 9) == 0) begin
            beats.push_back('{b: CH_BACKSLASH, eos: 1'b0});
        end
        beats[beats.size()-1].eos = 1'b1;
    endtask

    // receiver: random stretches of full rate, random and sparse ready,
    // plus one long hold-off while the sender keeps offering
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!held && n_sent >= 1400) begin
            held      = 1'b1;
            hold_left = LONG_HOLD;
            m_ready  <= 1'b0;
        end else begin
            if (stretch == 0) begin
                stretch  = $urandom_range(10, 80);
                rx_style = $urandom_range(0, 2);
            end
            stretch--;
            case (rx_style)
                0:       m_ready <= 1'b1;
                1:       m_ready <= 1'($urandom_range(0, 1));
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin : check_chars
        char_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_chars.size() == 0) begin
                n_errors++;
                if (n_errors <= 40) begin
                    $display("%0t: unexpected char_out %0d final_char %0d", $time,
                             m_char_out, m_final_char);
                end
            end else begin
                want = due_chars.pop_front();
                n_checked++;
                if (m_char_out !== want.code) begin
                    n_errors++;
                    if (n_errors <= 40) begin
                        $display("%0t: char_out expected %0d got %0d", $time,
                                 want.code, m_char_out);
                    end
                end
                if (m_final_char !== want.fin) begin
                    n_errors++;
                    if (n_errors <= 40) begin
                        $display("%0t: final_char expected %0d got %0d", $time,
                                 want.fin, m_final_char);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin
        in_beat_t beats [$];
        bit paused;
        paused = 1'b0;
        clear_octal();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED[i]) begin
            send_item(DIRECTED[i].b, DIRECTED[i].eos, !DIRECTED[i].typed);
            if (DIRECTED[i].typed) begin
                if (DIRECTED[i].n >= 2'd1) begin
                    due_chars.push_back('{code: DIRECTED[i].c0, fin: DIRECTED[i].f0});
                end
                if (DIRECTED[i].n == 2'd2) begin
                    due_chars.push_back('{code: DIRECTED[i].c1, fin: DIRECTED[i].f1});
                end
            end
        end

        while (n_sent < N_ITEMS) begin
            if (!paused && n_sent >= 1000) begin
                // drain completely before going on
                paused  = 1'b1;
                s_valid <= 1'b0;
                do @(posedge aclk); while (due_chars.size() != 0);
            end
            build_string(beats);
            foreach (beats[i]) send_item(beats[i].b, beats[i].eos, 1'b1);
        end

        s_valid <= 1'b0;
        while (due_chars.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Decoded %0d bytes over %0d strings (directed table plus random strings),",
                 n_sent, n_strings);
        $display("checked %0d characters under sender gaps and receiver stalls.", n_checked);
        if (n_errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
